FILE: rtl/gtfe_pkg.sv
// gtfe_pkg: shared types and constants of the glyph text framebuffer engine.
// No dependencies; used by gtfe_control, gtfe_datapath and the core by scoped name.
package gtfe_pkg;

   typedef enum logic [2:0] {
      FUNC_LOAD      = 3'd0,
      FUNC_DRAW      = 3'd1,
      FUNC_CLEAR     = 3'd2,
      FUNC_READ      = 3'd3,
      FUNC_ROT_DOWN  = 3'd4,
      FUNC_ROT_UP    = 3'd5,
      FUNC_ROT_RIGHT = 3'd6,
      FUNC_ROT_LEFT  = 3'd7
   } func_type;

   localparam logic [1:0] LINE_ONE   = 2'd1;
   localparam logic [1:0] LINE_TWO   = 2'd2;
   localparam logic [7:0] SPACE_CODE = 8'd32;
   localparam logic [7:0] FIRST_CODE = 8'd32;
   localparam logic [7:0] LAST_CODE  = 8'd126;
   localparam int PAGE_COUNT = 4;
   localparam logic [1:0] LAST_PAGE = 2'd3;

   typedef struct packed {
      func_type    func;
      logic [11:0] addr;
      logic [7:0]  data;
      logic [1:0]  line_select;
      logic [7:0]  symbol;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       full_res;
      logic       ignored;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic init_step;
      logic red_start;
      logic red_step;
      logic font_wr;
      logic frame_rd;
      logic clear_cursors;
      logic draw_select;
      logic set_full;
      logic width_rd;
      logic width_cap;
      logic col_hi;
      logic col_lo;
      logic col_wr;
      logic clip;
      logic finish;
      logic rot_start;
      logic rot_step;
      logic rot_flip;
      logic set_ignored;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     over_end;
      logic     lead_space;
      logic     bad_code;
      logic     red_done;
      logic     cols_done;
      logic     clip_hit;
      logic     rot_last;
      logic     init_last;
   } status_type;

endpackage

FILE: rtl/gtfe_ram.sv
// gtfe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gtfe_control.sv
// gtfe_control: transaction sequencer of the glyph engine.
// Depends on gtfe_pkg; drives gtfe_datapath through cmd_type / status_type.
module gtfe_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  gtfe_pkg::status_type   status,
   output gtfe_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DECODE, S_LRED, S_RRED, S_RWAIT, S_DCHK, S_GRED,
      S_WWAIT, S_CCHK, S_CHI, S_CLO, S_ROT, S_ROTEND, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.func)
               gtfe_pkg::FUNC_LOAD: begin
                  cmd.red_start = 1'b1;
                  state_in      = S_LRED;
               end
               gtfe_pkg::FUNC_READ: begin
                  cmd.red_start = 1'b1;
                  state_in      = S_RRED;
               end
               gtfe_pkg::FUNC_CLEAR: begin
                  cmd.clear_cursors = 1'b1;
                  state_in          = S_DONE;
               end
               gtfe_pkg::FUNC_DRAW: begin
                  if (status.full) begin
                     cmd.set_ignored = 1'b1;
                     state_in        = S_DONE;
                  end else begin
                     cmd.draw_select = 1'b1;
                     state_in        = S_DCHK;
                  end
               end
               default: begin
                  cmd.rot_start = 1'b1;
                  state_in      = S_ROT;
               end
            endcase
         end
         S_LRED: begin
            if (status.red_done) begin
               cmd.font_wr = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_RRED: begin
            if (status.red_done) begin
               cmd.frame_rd = 1'b1;
               state_in     = S_RWAIT;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_RWAIT: begin
            state_in = S_DONE;
         end
         S_DCHK: begin
            if (status.over_end) begin
               cmd.set_full    = 1'b1;
               cmd.set_ignored = 1'b1;
               state_in        = S_DONE;
            end else if (status.lead_space || status.bad_code) begin
               cmd.set_ignored = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.red_start = 1'b1;
               state_in      = S_GRED;
            end
         end
         S_GRED: begin
            if (status.red_done) begin
               cmd.width_rd = 1'b1;
               state_in     = S_WWAIT;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_WWAIT: begin
            cmd.width_cap = 1'b1;
            state_in      = S_CCHK;
         end
         S_CCHK: begin
            if (status.cols_done) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else if (status.clip_hit) begin
               cmd.clip = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.col_hi = 1'b1;
               state_in   = S_CHI;
            end
         end
         S_CHI: begin
            cmd.col_lo = 1'b1;
            state_in   = S_CLO;
         end
         S_CLO: begin
            cmd.col_wr = 1'b1;
            state_in   = S_CCHK;
         end
         S_ROT: begin
            cmd.rot_step = 1'b1;
            if (status.rot_last) begin
               state_in = S_ROTEND;
            end
         end
         S_ROTEND: begin
            cmd.rot_flip = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/gtfe_datapath.sv
// gtfe_datapath: cursors, modulo reducer, font RAM and two framebuffer banks.
// Depends on gtfe_pkg and gtfe_ram; steered by gtfe_control.
module gtfe_datapath #(
   parameter int PAGE_COLUMNS    = 128,
   parameter int GLYPH_STRIDE    = 25,
   parameter int FONT_DEPTH      = 4096,
   parameter int MAX_GLYPH_WIDTH = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gtfe_pkg::req_type    req_data,
   input  gtfe_pkg::cmd_type    cmd,
   output gtfe_pkg::status_type status,
   output gtfe_pkg::rsp_type    rsp_data
);

   localparam int FB    = gtfe_pkg::PAGE_COUNT * PAGE_COLUMNS;
   localparam int FB_W  = $clog2(FB);
   localparam int FA_W  = $clog2(FONT_DEPTH);
   localparam int COL_W = $clog2(PAGE_COLUMNS);
   localparam int CUR_W = $clog2(3 * PAGE_COLUMNS + 1);
   localparam int POS_W = CUR_W + 1;
   localparam int IW_W  = $clog2(MAX_GLYPH_WIDTH + 1);
   localparam int RED_W = $clog2(GLYPH_STRIDE * 94 + FONT_DEPTH + 4096);

   gtfe_pkg::req_type req_ff;
   gtfe_pkg::rsp_type rsp_ff;
   logic [CUR_W-1:0] cur_ff, first_ff, second_ff;
   logic [CUR_W-1:0] cur_in, first_in, second_in;
   logic             on2_ff, on2_in, full_ff, full_in, ign_ff, ign_in;
   logic [RED_W-1:0] red_ff, red_in, mod_ff, mod_in;
   logic [FA_W-1:0]  ptr_ff, ptr_in;
   logic [IW_W-1:0]  idx_ff, idx_in, width_ff, width_in;
   logic [1:0]       rpage_ff, rpage_in;
   logic [COL_W-1:0] rcol_ff, rcol_in;
   logic             wpend_ff, wpend_in, act_ff, act_in;
   logic [FB_W-1:0]  wdest_ff, wdest_in, init_ff, init_in;

   logic [POS_W-1:0] pos;
   logic [FB_W-1:0]  pos_addr, lo_addr, rot_dest, rot_src;
   logic [1:0]       src_page;
   logic [COL_W-1:0] src_col;
   logic [FA_W-1:0]  font_rd_addr, red_fa;
   logic [7:0]       font_q, frame_q, frame_q0, frame_q1, frame_wdata;
   logic             frame_we, frame_wbank, frame_rd_en;
   logic [FB_W-1:0]  frame_waddr, frame_raddr;

   function automatic logic [FA_W-1:0] fa_inc(input logic [FA_W-1:0] p);
      fa_inc = (p == FA_W'(FONT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pos      = POS_W'(cur_ff) + POS_W'(idx_ff);
   assign pos_addr = pos[FB_W-1:0];
   assign lo_addr  = pos_addr + FB_W'(PAGE_COLUMNS);
   assign red_fa   = red_ff[FA_W-1:0];
   assign rot_dest = FB_W'(rpage_ff) * FB_W'(PAGE_COLUMNS) + FB_W'(rcol_ff);

   always_comb begin
      src_page = rpage_ff;
      src_col  = rcol_ff;
      case (req_ff.func)
         gtfe_pkg::FUNC_ROT_DOWN: src_page = rpage_ff - 2'd1;
         gtfe_pkg::FUNC_ROT_UP:   src_page = rpage_ff + 2'd1;
         gtfe_pkg::FUNC_ROT_RIGHT: begin
            src_col = (rcol_ff == '0) ? COL_W'(PAGE_COLUMNS - 1) : rcol_ff - 1'b1;
         end
         gtfe_pkg::FUNC_ROT_LEFT: begin
            src_col = (rcol_ff == COL_W'(PAGE_COLUMNS - 1)) ? '0 : rcol_ff + 1'b1;
         end
         default: begin
            src_page = rpage_ff;
         end
      endcase
   end

   assign rot_src = FB_W'(src_page) * FB_W'(PAGE_COLUMNS) + FB_W'(src_col);

   always_comb begin
      status.func       = req_ff.func;
      status.full       = full_ff;
      status.over_end   = cur_ff > CUR_W'(3 * PAGE_COLUMNS - 1);
      status.lead_space = (req_ff.symbol == gtfe_pkg::SPACE_CODE)
                          && (cur_ff == CUR_W'(2 * PAGE_COLUMNS));
      status.bad_code   = (req_ff.symbol < gtfe_pkg::FIRST_CODE)
                          || (req_ff.symbol > gtfe_pkg::LAST_CODE);
      status.red_done   = red_ff < mod_ff;
      status.cols_done  = idx_ff == width_ff;
      status.clip_hit   = (!on2_ff && pos > POS_W'(PAGE_COLUMNS - 1))
                          || (pos > POS_W'(3 * PAGE_COLUMNS - 1));
      status.rot_last   = (rpage_ff == gtfe_pkg::LAST_PAGE)
                          && (rcol_ff == COL_W'(PAGE_COLUMNS - 1));
      status.init_last  = init_ff == FB_W'(FB - 1);
   end

   always_comb begin
      cur_in    = cur_ff;
      first_in  = first_ff;
      second_in = second_ff;
      on2_in    = on2_ff;
      full_in   = full_ff;
      ign_in    = ign_ff;
      red_in    = red_ff;
      mod_in    = mod_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      width_in  = width_ff;
      rpage_in  = rpage_ff;
      rcol_in   = rcol_ff;
      wpend_in  = 1'b0;
      wdest_in  = wdest_ff;
      act_in    = act_ff;
      init_in   = init_ff;
      if (cmd.init_step) begin
         init_in = init_ff + 1'b1;
      end
      if (cmd.latch_req) begin
         ign_in = 1'b0;
      end
      if (cmd.red_start) begin
         if (req_ff.func == gtfe_pkg::FUNC_DRAW) begin
            red_in = RED_W'(GLYPH_STRIDE) * RED_W'(req_ff.symbol - gtfe_pkg::FIRST_CODE);
            mod_in = RED_W'(FONT_DEPTH);
         end else begin
            red_in = RED_W'(req_ff.addr);
            mod_in = (req_ff.func == gtfe_pkg::FUNC_READ) ? RED_W'(FB) : RED_W'(FONT_DEPTH);
         end
      end
      if (cmd.red_step) begin
         red_in = red_ff - mod_ff;
      end
      if (cmd.clear_cursors) begin
         cur_in    = '0;
         first_in  = '0;
         second_in = CUR_W'(2 * PAGE_COLUMNS);
         full_in   = 1'b0;
      end
      if (cmd.draw_select) begin
         if (req_ff.line_select == gtfe_pkg::LINE_ONE) begin
            cur_in = first_ff;
            on2_in = 1'b0;
         end else if (req_ff.line_select == gtfe_pkg::LINE_TWO) begin
            cur_in = second_ff;
            on2_in = 1'b1;
         end
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.set_ignored) begin
         ign_in = 1'b1;
      end
      if (cmd.width_rd) begin
         ptr_in = fa_inc(red_fa);
      end
      if (cmd.width_cap) begin
         idx_in   = '0;
         width_in = (font_q > 8'(MAX_GLYPH_WIDTH)) ? IW_W'(MAX_GLYPH_WIDTH)
                                                   : font_q[IW_W-1:0];
      end
      if (cmd.col_hi || cmd.col_lo) begin
         ptr_in = fa_inc(ptr_ff);
      end
      if (cmd.col_wr) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.clip) begin
         cur_in = pos[CUR_W-1:0];
      end
      if (cmd.finish) begin
         cur_in = cur_ff + CUR_W'(width_ff);
         if (req_ff.line_select == gtfe_pkg::LINE_ONE) begin
            first_in = first_ff + CUR_W'(width_ff);
         end else if (req_ff.line_select == gtfe_pkg::LINE_TWO) begin
            second_in = second_ff + CUR_W'(width_ff);
         end
      end
      if (cmd.rot_start) begin
         rpage_in = '0;
         rcol_in  = '0;
      end
      if (cmd.rot_step) begin
         wpend_in = 1'b1;
         wdest_in = rot_dest;
         if (rcol_ff == COL_W'(PAGE_COLUMNS - 1)) begin
            rcol_in  = '0;
            rpage_in = rpage_ff + 2'd1;
         end else begin
            rcol_in = rcol_ff + 1'b1;
         end
      end
      if (cmd.rot_flip) begin
         act_in = ~act_ff;
      end
   end

   // upper glyph byte goes out in S_CHI, lower byte one page down in S_CLO
   always_comb begin
      frame_we    = 1'b0;
      frame_wbank = act_ff;
      frame_waddr = pos_addr;
      frame_wdata = font_q;
      if (cmd.init_step) begin
         frame_we    = 1'b1;
         frame_wbank = 1'b0;
         frame_waddr = init_ff;
         frame_wdata = '0;
      end else if (wpend_ff) begin
         frame_we    = 1'b1;
         frame_wbank = ~act_ff;
         frame_waddr = wdest_ff;
         frame_wdata = frame_q;
      end else if (cmd.col_lo) begin
         frame_we    = 1'b1;
         frame_waddr = pos_addr;
      end else if (cmd.col_wr) begin
         frame_we    = 1'b1;
         frame_waddr = lo_addr;
      end
   end

   assign frame_rd_en  = cmd.frame_rd || cmd.rot_step;
   assign frame_raddr  = cmd.frame_rd ? red_ff[FB_W-1:0] : rot_src;
   assign frame_q      = act_ff ? frame_q1 : frame_q0;
   assign font_rd_addr = cmd.width_rd ? red_fa : ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         first_ff  <= '0;
         second_ff <= CUR_W'(2 * PAGE_COLUMNS);
         on2_ff    <= 1'b0;
         full_ff   <= 1'b0;
         wpend_ff  <= 1'b0;
         act_ff    <= 1'b0;
         init_ff   <= '0;
      end else begin
         cur_ff    <= cur_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         on2_ff    <= on2_in;
         full_ff   <= full_in;
         wpend_ff  <= wpend_in;
         act_ff    <= act_in;
         init_ff   <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff.read_data <= (req_ff.func == gtfe_pkg::FUNC_READ) ? frame_q : 8'd0;
         rsp_ff.full_res  <= full_ff;
         rsp_ff.ignored   <= ign_ff;
      end
      ign_ff   <= ign_in;
      red_ff   <= red_in;
      mod_ff   <= mod_in;
      ptr_ff   <= ptr_in;
      idx_ff   <= idx_in;
      width_ff <= width_in;
      rpage_ff <= rpage_in;
      rcol_ff  <= rcol_in;
      wdest_ff <= wdest_in;
   end

   assign rsp_data = rsp_ff;

   gtfe_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
      .clock   (clock),
      .wr_en   (cmd.font_wr),
      .wr_addr (red_fa),
      .wr_data (req_ff.data),
      .rd_en   (cmd.width_rd || cmd.col_hi || cmd.col_lo),
      .rd_addr (font_rd_addr),
      .rd_data (font_q)
   );

   gtfe_ram #(.WIDTH(8), .DEPTH(FB)) u_frame0 (
      .clock   (clock),
      .wr_en   (frame_we && !frame_wbank),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_en   (frame_rd_en),
      .rd_addr (frame_raddr),
      .rd_data (frame_q0)
   );

   gtfe_ram #(.WIDTH(8), .DEPTH(FB)) u_frame1 (
      .clock   (clock),
      .wr_en   (frame_we && frame_wbank),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_en   (frame_rd_en),
      .rd_addr (frame_raddr),
      .rd_data (frame_q1)
   );

endmodule

FILE: rtl/glyph_text_framebuffer_engine_core.sv
// glyph_text_framebuffer_engine_core: top level of the glyph text engine.
// Depends on gtfe_pkg, gtfe_control, gtfe_datapath (and gtfe_ram below it).
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (gtfe_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (gtfe_pkg::rsp_type)
//
// One transaction at a time. Load and read reduce the address by repeated
// subtraction; draw reduces the glyph offset, reads the glyph width, then two
// font bytes per glyph column through the single font RAM read port; scroll
// copies one framebuffer byte between banks per cycle. After reset an init
// pass clears framebuffer bank 0, the active one; req_ready stays low meanwhile.
// A stalled rsp holds; the next req is taken meanwhile.
module glyph_text_framebuffer_engine_core #(
   parameter int PAGE_COLUMNS    = 128,
   parameter int GLYPH_STRIDE    = 25,
   parameter int FONT_DEPTH      = 4096,
   parameter int MAX_GLYPH_WIDTH = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gtfe_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gtfe_pkg::rsp_type  rsp_data
);

   gtfe_pkg::cmd_type    cmd;
   gtfe_pkg::status_type status;

   gtfe_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gtfe_datapath #(
      .PAGE_COLUMNS    (PAGE_COLUMNS),
      .GLYPH_STRIDE    (GLYPH_STRIDE),
      .FONT_DEPTH      (FONT_DEPTH),
      .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for glyph_text_framebuffer_engine_core.
// Depends on gtfe_pkg and the core; drives requests, predicts and checks responses.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS = 128;
   localparam int FRAME_BYTES = 4 * COLS;
   localparam int STRIDE = 25;
   localparam int FDEPTH = 4096;
   localparam int MAXW = 12;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   gtfe_pkg::req_type req_data;
   gtfe_pkg::rsp_type rsp_data;

   glyph_text_framebuffer_engine_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   gtfe_pkg::req_type pending_reqs[$];
   gtfe_pkg::rsp_type expected_rsps[$];
   int mismatches = 0;
   bit quiet_tail = 0;
   bit hold_rsp = 0;
   int send_gap = 0, recv_gap = 0;

   logic [7:0] fb[FRAME_BYTES];
   logic [7:0] font[FDEPTH];
   int cur, line1_cur, line2_cur;
   bit on_line2, full;

   function automatic bit draw_glyph(logic [1:0] ls, logic [7:0] sym);
      int base, w, pos;
      if (full) return 1;
      if (ls == gtfe_pkg::LINE_ONE) begin
         cur = line1_cur; on_line2 = 0;
      end else if (ls == gtfe_pkg::LINE_TWO) begin
         cur = line2_cur; on_line2 = 1;
      end
      if (cur > 3 * COLS - 1) begin
         full = 1;
         return 1;
      end
      if (sym == gtfe_pkg::SPACE_CODE && cur == 2 * COLS) return 1;
      if (sym < gtfe_pkg::FIRST_CODE || sym > gtfe_pkg::LAST_CODE) return 1;
      base = STRIDE * (sym - gtfe_pkg::FIRST_CODE);
      w = font[base % FDEPTH];
      if (w > MAXW) w = MAXW;
      for (int i = 0; i < w; i++) begin
         pos = cur + i;
         if ((!on_line2 && pos > COLS - 1) || pos > 3 * COLS - 1) begin
            cur = pos;
            return 0;
         end
         fb[pos % FRAME_BYTES] = font[(base + 2 * i + 1) % FDEPTH];
         fb[(pos + COLS) % FRAME_BYTES] = font[(base + 2 * i + 2) % FDEPTH];
      end
      cur += w;
      if (ls == gtfe_pkg::LINE_ONE) line1_cur += w;
      else if (ls == gtfe_pkg::LINE_TWO) line2_cur += w;
      return 0;
   endfunction

   function automatic gtfe_pkg::rsp_type predict_engine(gtfe_pkg::req_type r);
      gtfe_pkg::rsp_type o;
      logic [7:0] old[FRAME_BYTES];
      o = '0;
      old = fb;
      case (r.func)
         gtfe_pkg::FUNC_LOAD: font[r.addr % FDEPTH] = r.data;
         gtfe_pkg::FUNC_DRAW: o.ignored = draw_glyph(r.line_select, r.symbol);
         gtfe_pkg::FUNC_CLEAR: begin
            cur = 0; line1_cur = 0; line2_cur = 2 * COLS; full = 0;
         end
         gtfe_pkg::FUNC_READ: o.read_data = fb[r.addr % FRAME_BYTES];
         gtfe_pkg::FUNC_ROT_DOWN:
            for (int i = 0; i < FRAME_BYTES; i++)
               fb[i] = old[(i + FRAME_BYTES - COLS) % FRAME_BYTES];
         gtfe_pkg::FUNC_ROT_UP:
            for (int i = 0; i < FRAME_BYTES; i++) fb[i] = old[(i + COLS) % FRAME_BYTES];
         gtfe_pkg::FUNC_ROT_RIGHT:
            for (int p = 0; p < 4; p++)
               for (int c = 0; c < COLS; c++)
                  fb[p * COLS + c] = old[p * COLS + (c + COLS - 1) % COLS];
         default:
            for (int p = 0; p < 4; p++)
               for (int c = 0; c < COLS; c++)
                  fb[p * COLS + c] = old[p * COLS + (c + 1) % COLS];
      endcase
      o.full_res = full;
      return o;
   endfunction

   function automatic gtfe_pkg::req_type make_req(gtfe_pkg::func_type f, int a, int d,
                                                  int ls, int s);
      gtfe_pkg::req_type r;
      r.func = f; r.addr = 12'(a); r.data = 8'(d); r.line_select = 2'(ls);
      r.symbol = 8'(s);
      return r;
   endfunction

   // drawn codes come from a small set whose glyph records are loaded
   function automatic int pick_code();
      int k;
      k = $urandom_range(0, 8);
      return (k == 8) ? 126 : 32 + k;
   endfunction

   function automatic int pick_bad_code();
      return $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(127, 255);
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) begin
            expected_rsps.push_back(predict_engine(req_data));
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (pending_reqs.size() > 0 && (quiet_tail || $urandom_range(0, 7) != 0)) begin
            req_valid <= 1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 0;
            if (!quiet_tail && pending_reqs.size() > 0) send_gap = $urandom_range(0, 2);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               gtfe_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", e, rsp_data);
               end
            end
         end
         if (hold_rsp) rsp_ready <= 0;
         else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rsp_ready <= 0;
         end else rsp_ready <= 1;
      end
   end

   // long receiver hold-off
   initial begin
      int n;
      @(negedge reset);
      repeat (1000) @(posedge clock);
      hold_rsp = 1;
      n = 0;
      while (n < 300) begin
         @(posedge clock);
         n++;
      end
      hold_rsp = 0;
   end

   initial begin
      #200_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int k, s, a, code;
      for (int i = 0; i < FRAME_BYTES; i++) fb[i] = 0;
      for (int i = 0; i < FDEPTH; i++) font[i] = 0;
      cur = 0; line1_cur = 0; line2_cur = 2 * COLS; on_line2 = 0; full = 0;
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      // glyph records of every code that is drawn, before any draw
      for (int g = 0; g < 9; g++) begin
         code = (g == 8) ? 126 : 32 + g;
         for (int j = 0; j < STRIDE; j++) begin
            a = STRIDE * (code - 32) + j;
            if (j == 0)
               k = ((code - 32) % 3 == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
            else k = $urandom_range(0, 255);
            pending_reqs.push_back(make_req(gtfe_pkg::FUNC_LOAD, a, k, $urandom_range(0, 3),
                                            $urandom_range(0, 255)));
         end
      end
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_LOAD, 12'hfff, 8'hff, 3, 255));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_LOAD, 12'hfff, 8'h00, 0, 0));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, 0, 0, gtfe_pkg::LINE_TWO,
                                      gtfe_pkg::SPACE_CODE));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, 0, 0, gtfe_pkg::LINE_ONE, 31));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, 0, 0, gtfe_pkg::LINE_ONE, 127));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, 0, 0, 0, 126));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, 0, 0, 3, 33));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_READ, 12'hfff, 0, 0, 0));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_READ, 0, 0, 0, 0));
      for (int f = 4; f < 8; f++)
         pending_reqs.push_back(make_req(gtfe_pkg::func_type'(f), 0, 0, 0, 0));
      pending_reqs.push_back(make_req(gtfe_pkg::FUNC_CLEAR, 0, 0, 0, 0));
      // fill both lines to overflow
      for (int i = 0; i < 40; i++)
         pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, 0, 0,
                                         (i % 2) ? gtfe_pkg::LINE_TWO : gtfe_pkg::LINE_ONE,
                                         pick_code()));
      for (int i = 0; i < 250; i++) begin
         k = $urandom_range(0, 99);
         if (k < 55) begin
            s = ($urandom_range(0, 9) == 0) ? pick_bad_code() : pick_code();
            pending_reqs.push_back(make_req(gtfe_pkg::FUNC_DRAW, $urandom_range(0, 4095),
                                   $urandom_range(0, 255), $urandom_range(0, 3), s));
         end else if (k < 75)
            pending_reqs.push_back(make_req(gtfe_pkg::FUNC_READ, $urandom_range(0, 4095),
                                   $urandom_range(0, 255), $urandom_range(0, 3),
                                   $urandom_range(0, 255)));
         else if (k < 82)
            pending_reqs.push_back(make_req(gtfe_pkg::FUNC_CLEAR, $urandom_range(0, 4095), 0,
                                   $urandom_range(0, 3), 0));
         else if (k < 88)
            pending_reqs.push_back(make_req(gtfe_pkg::FUNC_LOAD, $urandom_range(0, 4095),
                                   $urandom_range(0, 255), 0, 0));
         else
            pending_reqs.push_back(make_req(gtfe_pkg::func_type'($urandom_range(4, 7)),
                                   $urandom_range(0, 4095), 0, 0, 0));
         if (i == 200) pending_reqs.push_back(make_req(gtfe_pkg::FUNC_CLEAR, 0, 0, 0, 0));
      end
      while (pending_reqs.size() > 60) @(posedge clock);
      quiet_tail = 1;
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

FILE: files.f
rtl/gtfe_pkg.sv
rtl/gtfe_ram.sv
rtl/gtfe_control.sv
rtl/gtfe_datapath.sv
rtl/glyph_text_framebuffer_engine_core.sv
tb/testbench.sv
